/* src/mrc_pkg.sv */
`timescale 1ns / 1ps

package mrc_pkg;

  localparam int unsigned MaxRegsDefault = 64;
  localparam int unsigned CrcSteps       = 8;
  localparam int unsigned CfgAddrW       = 4;
  localparam int unsigned CfgDataW       = 32;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] FcReadHolding = 8'h03;
  localparam logic [7:0] FcReadInput   = 8'h04;

  localparam logic [8:0] ReadMinLen = 9'd5;
  localparam logic [8:0] EchoLen    = 9'd8;

  typedef enum logic [1:0] {
    FN_BYTE    = 2'd0,
    FN_TIMEOUT = 2'd1,
    FN_BEGIN   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_TIMEOUT = 3'd1,
    STAT_FAIL    = 3'd2,
    STAT_SIZE    = 3'd3,
    STAT_CRC     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_SLAVE = 2'd0,
    REG_FUNC  = 2'd1,
    REG_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_WAIT,
    S_CRC,
    S_CHECK,
    S_READ,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] reg_value;
    logic [5:0]  reg_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic init;
    logic load;
  } crc_ctl_t;

endpackage

/* src/mrc_ram.sv */
`timescale 1ns / 1ps

module mrc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/mrc_crc.sv */
`timescale 1ns / 1ps

module mrc_crc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrc_pkg::crc_ctl_t ctl_i,
  input  logic [7:0]        byte_i,
  output logic [15:0]       crc_o,
  output logic              busy_o
);

  localparam int unsigned CntW = $clog2(mrc_pkg::CrcSteps + 1);

  logic [15:0]     crc_q, crc_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (ctl_i.init) begin
      crc_d = mrc_pkg::CrcInit;
      cnt_d = '0;
    end else if (ctl_i.load) begin
      crc_d = crc_q ^ {8'h00, byte_i};
      cnt_d = CntW'(mrc_pkg::CrcSteps);
    end else if (cnt_q != '0) begin
      // one reflected shift per cycle
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ mrc_pkg::CrcPoly) : (crc_q >> 1);
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= mrc_pkg::CrcInit;
      cnt_q <= '0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

  assign crc_o  = crc_q;
  assign busy_o = (cnt_q != '0);

endmodule

/* src/modbus_rtu_response_checker.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Word
// in       input      in_valid_i / in_stall_o   mrc_pkg::in_item_t
// out      output     out_valid_o / out_stall_i mrc_pkg::out_item_t
// cfg      input      APB psel/penable/pready   32-bit registers at 0x0, 0x4, 0x8
//
// A received byte is accepted in S_WAIT; S_CRC waits out its 8 bit-serial CRC steps,
// then returns to idle, or to S_CHECK for the verdict once the reply is in. A timeout
// or a rejected begin goes to S_CHECK. A good read reply reads each word in S_READ
// (registered read) and emits it in S_EMIT, taking no input meanwhile. Reset needs no
// clearing pass. A stalled result holds in the output register; the block accepts the
// next word meanwhile and waits only when it has a new result to load.

module modbus_rtu_response_checker #(
  parameter int unsigned MAX_REGS = mrc_pkg::MaxRegsDefault,
  localparam int unsigned AddrW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mrc_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mrc_pkg::out_item_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [mrc_pkg::CfgDataW-1:0]  pwdata,
  output logic [mrc_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  localparam logic [6:0] MaxRegsW = 7'(MAX_REGS);

  // configuration
  logic [7:0] slave_q, func_code_q;
  logic [6:0] reg_count_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q     <= 8'd1;
      func_code_q <= 8'd3;
      reg_count_q <= 7'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mrc_pkg::REG_SLAVE: slave_q     <= pwdata[7:0];
        mrc_pkg::REG_FUNC:  func_code_q <= pwdata[7:0];
        mrc_pkg::REG_COUNT: reg_count_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mrc_pkg::REG_SLAVE: prdata = {24'd0, slave_q};
      mrc_pkg::REG_FUNC:  prdata = {24'd0, func_code_q};
      mrc_pkg::REG_COUNT: prdata = {25'd0, reg_count_q};
      default:            prdata = '0;
    endcase
  end

  logic       is_read, count_ok;
  logic [8:0] wanted_len;

  assign is_read    = (func_code_q == mrc_pkg::FcReadHolding) ||
                      (func_code_q == mrc_pkg::FcReadInput);
  assign count_ok   = (reg_count_q != 7'd0) && (reg_count_q <= MaxRegsW);
  assign wanted_len = is_read ? (mrc_pkg::ReadMinLen + {1'b0, reg_count_q, 1'b0})
                              : mrc_pkg::EchoLen;

  // control state
  mrc_pkg::ctrl_state_e state_q, state_d;
  logic       phase_q, phase_d;
  logic [7:0] rx_cnt_q, rx_cnt_d;
  logic       hdr_err_q, hdr_err_d;
  logic [7:0] hold_q, hold_d;
  logic [6:0] rd_idx_q, rd_idx_d;
  logic       out_valid_q, out_valid_d;
  mrc_pkg::out_item_t out_q, out_d;

  logic               in_acc, out_free;
  mrc_pkg::crc_ctl_t  crc_ctl;
  logic [15:0]        crc;
  logic               crc_busy;
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr;
  logic [15:0]        ram_wdata, ram_rdata;

  logic [7:0]         rx_b;
  logic [7:0]         off;
  logic [6:0]         word_idx;
  logic               in_data_area;
  logic [2:0]         verdict;
  logic               word_last;

  assign in_stall_o = (state_q != mrc_pkg::S_WAIT);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  assign rx_b         = in_data_i.rx_byte;
  assign off          = rx_cnt_q - 8'd3;
  assign word_idx     = off[7:1];
  assign in_data_area = is_read && (rx_cnt_q >= 8'd3) &&
                        (({1'b0, rx_cnt_q} + 9'd2) < wanted_len);
  assign word_last    = ((rd_idx_q + 7'd1) == reg_count_q);

  // verdict in check order
  always_comb begin
    if (is_read && !count_ok) begin
      verdict = mrc_pkg::STAT_FAIL;
    end else if ({1'b0, rx_cnt_q} < (is_read ? mrc_pkg::ReadMinLen : mrc_pkg::EchoLen)) begin
      verdict = mrc_pkg::STAT_TIMEOUT;
    end else if (hdr_err_q) begin
      verdict = mrc_pkg::STAT_FAIL;
    end else if (is_read && ({1'b0, rx_cnt_q} != wanted_len)) begin
      verdict = mrc_pkg::STAT_SIZE;
    end else if (crc != 16'd0) begin
      verdict = mrc_pkg::STAT_CRC;
    end else begin
      verdict = mrc_pkg::STAT_OK;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    rx_cnt_d    = rx_cnt_q;
    hdr_err_d   = hdr_err_q;
    hold_d      = hold_q;
    rd_idx_d    = rd_idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    crc_ctl     = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = word_idx[AddrW-1:0];
    ram_wdata   = {hold_q, rx_b};

    case (state_q)
      mrc_pkg::S_WAIT: begin
        if (in_acc) begin
          case (in_data_i.func)
            mrc_pkg::FN_BEGIN: begin
              rx_cnt_d     = '0;
              hdr_err_d    = 1'b0;
              hold_d       = '0;
              crc_ctl.init = 1'b1;
              if (is_read && !count_ok) begin
                phase_d = 1'b0;
                state_d = mrc_pkg::S_CHECK;
              end else begin
                phase_d = 1'b1;
              end
            end
            mrc_pkg::FN_TIMEOUT: begin
              if (phase_q) begin
                state_d = mrc_pkg::S_CHECK;
              end
            end
            mrc_pkg::FN_BYTE: begin
              if (phase_q) begin
                crc_ctl.load = 1'b1;
                if ((rx_cnt_q == 8'd0) && (rx_b != slave_q)) begin
                  hdr_err_d = 1'b1;
                end
                if ((rx_cnt_q == 8'd1) && (rx_b != func_code_q)) begin
                  hdr_err_d = 1'b1;
                end
                if (is_read && (rx_cnt_q == 8'd2) && (rx_b != {reg_count_q, 1'b0})) begin
                  hdr_err_d = 1'b1;
                end
                if (in_data_area) begin
                  if (!off[0]) begin
                    hold_d = rx_b;
                  end else if (word_idx < MaxRegsW) begin
                    ram_we = 1'b1;
                  end
                end
                if (rx_cnt_q != 8'hFF) begin
                  rx_cnt_d = rx_cnt_q + 8'd1;
                end
                state_d = mrc_pkg::S_CRC;
              end
            end
            default: ;
          endcase
        end
      end
      mrc_pkg::S_CRC: begin
        if (!crc_busy) begin
          state_d = ({1'b0, rx_cnt_q} >= wanted_len) ? mrc_pkg::S_CHECK : mrc_pkg::S_WAIT;
        end
      end
      mrc_pkg::S_CHECK: begin
        phase_d = 1'b0;
        if ((verdict == mrc_pkg::STAT_OK) && is_read) begin
          rd_idx_d = '0;
          state_d  = mrc_pkg::S_READ;
        end else if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.status    = verdict;
          out_d.reg_value = '0;
          out_d.reg_index = '0;
          out_d.last      = 1'b1;
          state_d         = mrc_pkg::S_WAIT;
        end
      end
      mrc_pkg::S_READ: begin
        ram_re  = 1'b1;
        state_d = mrc_pkg::S_EMIT;
      end
      mrc_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.status    = mrc_pkg::STAT_OK;
          out_d.reg_value = ram_rdata;
          out_d.reg_index = rd_idx_q[5:0];
          out_d.last      = word_last;
          if (word_last) begin
            state_d = mrc_pkg::S_WAIT;
          end else begin
            rd_idx_d = rd_idx_q + 7'd1;
            state_d  = mrc_pkg::S_READ;
          end
        end
      end
      default: state_d = mrc_pkg::S_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrc_pkg::S_WAIT;
      phase_q     <= 1'b0;
      rx_cnt_q    <= '0;
      hdr_err_q   <= 1'b0;
      hold_q      <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      rx_cnt_q    <= rx_cnt_d;
      hdr_err_q   <= hdr_err_d;
      hold_q      <= hold_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  mrc_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .byte_i (rx_b),
    .crc_o  (crc),
    .busy_o (crc_busy)
  );

  mrc_ram #(
    .Width (16),
    .Depth (MAX_REGS)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

endmodule
